FILE: hdl/stf_pkg.sv
// ----------------------------------------------------------------------------
// stf_pkg: shared constants and types for the sparse-tap FIR filter
// Field widths, register indexes, reset values and the control structs that
// pass between the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package stf_pkg;

  // Parameter defaults
  localparam int DELAY_DEPTH_DEF  = 32768;
  localparam int MAX_TAPS_DEF     = 1024;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 18;

  // Fixed field and register widths
  localparam int TAP_INDEX_WIDTH  = 10;
  localparam int TAP_OFFSET_WIDTH = 15;
  localparam int TAP_COUNT_WIDTH  = 10;
  localparam int GAIN_WIDTH       = 18;
  localparam int ACC_WIDTH        = 64;
  localparam int CHUNK_WIDTH      = 16;
  localparam int NUM_CHUNKS       = ACC_WIDTH / CHUNK_WIDTH;
  localparam int CFG_INDEX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH   = 18;

  // Configuration register indexes and reset values
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TAP_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTPUT_GAIN = 2'd1;
  localparam logic [TAP_COUNT_WIDTH-1:0] TAP_COUNT_RESET   = 10'd2;
  localparam logic [GAIN_WIDTH-1:0]      OUTPUT_GAIN_RESET = 18'd16384;

  // Item kinds carried in tuser
  localparam logic OP_LOAD_TAP = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
  } mac_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scl_stat_t;

endpackage

FILE: hdl/stf_tables.sv
// ----------------------------------------------------------------------------
// stf_tables: tap offset and coefficient memories
// One write port for tap loads, one registered read port for the tap walk.
// ----------------------------------------------------------------------------
module stf_tables #(
  parameter int MAX_TAPS    = stf_pkg::MAX_TAPS_DEF,
  parameter int DELAY_DEPTH = stf_pkg::DELAY_DEPTH_DEF,
  parameter int COEF_WIDTH  = stf_pkg::COEF_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(MAX_TAPS)-1:0]    wr_addr,
  input  logic [$clog2(DELAY_DEPTH)-1:0] wr_offset,
  input  logic [COEF_WIDTH-1:0]          wr_coef,
  input  logic [$clog2(MAX_TAPS)-1:0]    rd_addr,
  output logic [$clog2(DELAY_DEPTH)-1:0] rd_offset,
  output logic [COEF_WIDTH-1:0]          rd_coef
);
  import stf_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);

  logic [AW-1:0]         offset_mem [MAX_TAPS];
  logic [COEF_WIDTH-1:0] coef_mem   [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      offset_mem[wr_addr] <= wr_offset;
      coef_mem[wr_addr]   <= wr_coef;
    end
    rd_offset <= offset_mem[rd_addr];
    rd_coef   <= coef_mem[rd_addr];
  end

endmodule

FILE: hdl/stf_mac.sv
// ----------------------------------------------------------------------------
// stf_mac: shared multiply-accumulate unit
// Registers each sample * coefficient product, then adds it into a wrapping
// 64-bit accumulator.
// ----------------------------------------------------------------------------
module stf_mac #(
  parameter int SAMPLE_WIDTH = stf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = stf_pkg::COEF_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  stf_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample,
  input  logic signed [COEF_WIDTH-1:0]        coef,
  output stf_pkg::mac_stat_t                  stat,
  output logic [stf_pkg::ACC_WIDTH-1:0]       acc
);
  import stf_pkg::*;

  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;

  logic signed [PW-1:0] prod;
  logic                 prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.en;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PW'(sample) * PW'(coef);
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_WIDTH'(prod);
    end
  end

  assign stat.busy = prod_valid;

endmodule

FILE: hdl/stf_scale.sv
// ----------------------------------------------------------------------------
// stf_scale: gain scaling, rounding and saturation
// Multiplies the accumulator magnitude by the gain one 16-bit chunk a step,
// rounds half away from zero and clamps to the sample range.
// ----------------------------------------------------------------------------
module stf_scale #(
  parameter int SAMPLE_WIDTH = stf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = stf_pkg::COEF_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [stf_pkg::ACC_WIDTH-1:0]    acc,
  input  logic [stf_pkg::GAIN_WIDTH-1:0]   gain,
  output stf_pkg::scl_stat_t               stat,
  output logic [SAMPLE_WIDTH-1:0]          result
);
  import stf_pkg::*;

  localparam int PW    = ACC_WIDTH + GAIN_WIDTH;
  localparam int PPW   = CHUNK_WIDTH + GAIN_WIDTH;
  localparam int SHIFT = COEF_WIDTH + 14;
  localparam int QW    = PW - SHIFT;
  localparam int CW    = $clog2(NUM_CHUNKS);
  localparam logic [PW-1:0] ROUND  = PW'(1) << (SHIFT - 1);
  localparam logic [QW-1:0] MAXPOS = (QW'(1) << (SAMPLE_WIDTH - 1)) - QW'(1);
  localparam logic [QW-1:0] MAXNEG = QW'(1) << (SAMPLE_WIDTH - 1);
  localparam logic [CW-1:0] LAST_CHUNK = CW'(NUM_CHUNKS - 1);

  typedef enum logic [2:0] {
    SC_IDLE, SC_ABS, SC_MUL, SC_LAST, SC_ROUND, SC_SAT
  } sc_state_t;

  sc_state_t            state;
  logic [ACC_WIDTH-1:0] mag;
  logic [PPW-1:0]       pp;
  logic [PW-1:0]        sum;
  logic [CW-1:0]        cnt;
  logic                 neg;
  logic                 done;
  logic [QW-1:0]        q;
  logic [QW-1:0]        q_sat;

  always_comb begin
    q = sum[PW-1:SHIFT];
    if (neg) begin
      q_sat = (q > MAXNEG) ? MAXNEG : q;
    end else begin
      q_sat = (q > MAXPOS) ? MAXPOS : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        SC_IDLE: begin
          if (start) begin
            state <= SC_ABS;
          end
        end
        SC_ABS: begin
          neg   <= acc[ACC_WIDTH-1];
          mag   <= acc[ACC_WIDTH-1] ? (~acc + ACC_WIDTH'(1)) : acc;
          sum   <= '0;
          cnt   <= '0;
          state <= SC_MUL;
        end
        SC_MUL: begin
          // Take the top chunk; fold the previous partial product in.
          pp  <= mag[ACC_WIDTH-1 -: CHUNK_WIDTH] * gain;
          mag <= mag << CHUNK_WIDTH;
          if (cnt != '0) begin
            sum <= (sum << CHUNK_WIDTH) + PW'(pp);
          end
          cnt <= cnt + CW'(1);
          if (cnt == LAST_CHUNK) begin
            state <= SC_LAST;
          end
        end
        SC_LAST: begin
          sum   <= (sum << CHUNK_WIDTH) + PW'(pp);
          state <= SC_ROUND;
        end
        SC_ROUND: begin
          sum   <= sum + ROUND;
          state <= SC_SAT;
        end
        SC_SAT: begin
          result <= SAMPLE_WIDTH'(neg ? (~q_sat + QW'(1)) : q_sat);
          done   <= 1'b1;
          state  <= SC_IDLE;
        end
        default: begin
          state <= SC_IDLE;
        end
      endcase
    end
  end

  assign stat.done = done;
  assign stat.busy = (state != SC_IDLE);

endmodule

FILE: hdl/sparse_tap_fir_filter.sv
// ----------------------------------------------------------------------------
// sparse_tap_fir_filter: audio FIR filter with loadable tap offsets
// Circular delay line, offset and coefficient tables, one shared MAC walked
// over the taps by a small sequencer, then gain scaling and saturation.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: input items. tuser selects the kind: a tap load writes one tap's
//   offset and coefficient, a sample is stored in the delay line and filtered.
//   m_axis: one filtered sample per sample item; tap loads give no result.
//   cfg: plain register writes (tap_count, output_gain), only while idle.
// Timing
//   A sample makes one table read and one MAC step per tap (taps 1 .. tap_count-1,
//   with tap_count clamped to at least 2), then a pipeline drain, the chunked
//   gain multiplier and the output register; the next item is taken once the
//   sequencer is back in idle. The single MAC and the one read port of the
//   delay line set the pace of the tap walk.
//   A tap load runs the offset reduction that brings the offset below
//   DELAY_DEPTH and writes the tables at its last step.
//   s_axis_tready is high only between items.
// Reset
//   rst clears the write position and fill count and resets the registers. The
//   delay line is not swept: the fill count marks which entries hold samples
//   and the rest read as zero. Tap tables are undefined until loaded.
// Back-pressure
//   The result sits in an output register; a new item is accepted while it
//   waits, and the next result is held back until m_axis takes the old one.
// ----------------------------------------------------------------------------
module sparse_tap_fir_filter #(
  parameter int DELAY_DEPTH  = stf_pkg::DELAY_DEPTH_DEF,
  parameter int MAX_TAPS     = stf_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = stf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = stf_pkg::COEF_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // tdata, low bit up: tap_index, tap_offset, tap_coef, sample_in, zero fill
  input  logic [((stf_pkg::TAP_INDEX_WIDTH + stf_pkg::TAP_OFFSET_WIDTH
                  + COEF_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: op (load tap or sample)
  input  logic                                       s_axis_tuser,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata, low bit up: sample_out, zero fill
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]  m_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  input  logic                                       cfg_wen,
  input  logic [stf_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic [stf_pkg::CFG_DATA_WIDTH-1:0]         cfg_data
);
  import stf_pkg::*;

  localparam int AW       = $clog2(DELAY_DEPTH);
  localparam int TW       = $clog2(MAX_TAPS);
  localparam int TCW      = (TAP_COUNT_WIDTH > $clog2(MAX_TAPS + 1)) ?
                            TAP_COUNT_WIDTH : $clog2(MAX_TAPS + 1);
  localparam int IXW      = (TAP_INDEX_WIDTH > TW + 1) ? TAP_INDEX_WIDTH : TW + 1;
  localparam int OUT_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OFF_LO   = TAP_INDEX_WIDTH;
  localparam int COEF_LO  = OFF_LO + TAP_OFFSET_WIDTH;
  localparam int SAMP_LO  = COEF_LO + COEF_WIDTH;
  localparam int QSPAN    = ((1 << TAP_OFFSET_WIDTH) + DELAY_DEPTH - 1) / DELAY_DEPTH;
  localparam int QBITS    = (QSPAN > 1) ? $clog2(QSPAN) : 1;
  localparam int RW       = AW + QBITS + 1;
  localparam logic [RW-1:0]  D_RW     = RW'(DELAY_DEPTH);
  localparam logic [RW-1:0]  DSH_INIT = D_RW << (QBITS - 1);
  localparam logic [AW:0]    D_FULL   = (AW + 1)'(DELAY_DEPTH);
  localparam logic [AW-1:0]  POS_LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [TCW-1:0] TAPS_MIN = TCW'(2);
  localparam logic [TCW-1:0] TAPS_MAX = TCW'(MAX_TAPS);

  typedef enum logic [2:0] {
    S_IDLE, S_REDUCE, S_RUN, S_DRAIN, S_SCALE
  } state_t;

  // Input fields
  logic [TAP_INDEX_WIDTH-1:0]  in_idx;
  logic [TAP_OFFSET_WIDTH-1:0] in_off;
  logic [COEF_WIDTH-1:0]       in_coef;
  logic [SAMPLE_WIDTH-1:0]     in_sample;
  logic                        in_acc;

  // Registers
  state_t                     state;
  logic [TAP_COUNT_WIDTH-1:0] tap_count;
  logic [GAIN_WIDTH-1:0]      output_gain;
  logic [AW-1:0]              pos;
  logic [AW:0]                fill;
  logic [TW-1:0]              tap;
  logic [TW-1:0]              tap_last;
  logic [RW-1:0]              rem;
  logic [RW-1:0]              dsh;
  logic [TW-1:0]              load_idx;
  logic [COEF_WIDTH-1:0]      load_coef;
  logic [SAMPLE_WIDTH-1:0]    out_sample;

  // Tap walk pipeline
  logic                    v1;
  logic                    v2;
  logic [AW-1:0]           tab_offset;
  logic [COEF_WIDTH-1:0]   tab_coef;
  logic [COEF_WIDTH-1:0]   coef2;
  logic                    ok2;
  logic [SAMPLE_WIDTH-1:0] dl_mem [DELAY_DEPTH];
  logic [SAMPLE_WIDTH-1:0] dl_q;

  // Combinational
  logic [RW-1:0]  rem_next;
  logic           tab_we;
  logic           idx_ok;
  logic [TCW-1:0] tc_ext;
  logic [TCW-1:0] taps_c;
  logic [AW:0]    rd_sum;
  logic [AW-1:0]  rd_addr;
  logic [AW:0]    rd_dist;
  logic           rd_ok;
  logic           drained;
  logic           scl_start;

  mac_ctrl_t mac_ctrl;
  mac_stat_t mac_stat;
  scl_stat_t scl_stat;
  logic [ACC_WIDTH-1:0]    acc;
  logic [SAMPLE_WIDTH-1:0] scl_result;

  assign in_idx    = s_axis_tdata[TAP_INDEX_WIDTH-1:0];
  assign in_off    = s_axis_tdata[OFF_LO +: TAP_OFFSET_WIDTH];
  assign in_coef   = s_axis_tdata[COEF_LO +: COEF_WIDTH];
  assign in_sample = s_axis_tdata[SAMP_LO +: SAMPLE_WIDTH];

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign idx_ok        = IXW'(in_idx) < IXW'(MAX_TAPS);

  // Clamp the window to 2 .. MAX_TAPS
  always_comb begin
    tc_ext = TCW'(tap_count);
    if (tc_ext < TAPS_MIN) begin
      taps_c = TAPS_MIN;
    end else if (tc_ext > TAPS_MAX) begin
      taps_c = TAPS_MAX;
    end else begin
      taps_c = tc_ext;
    end
  end

  // One restoring step of offset mod DELAY_DEPTH per cycle
  assign rem_next = (rem >= dsh) ? (rem - dsh) : rem;
  assign tab_we   = (state == S_REDUCE) && (dsh == D_RW);

  // Delay read address and whether that entry has ever been written.
  // Written entries are pos, pos+1, ... going back fill samples.
  always_comb begin
    rd_sum  = {1'b0, pos} + {1'b0, tab_offset};
    rd_addr = (rd_sum >= D_FULL) ? AW'(rd_sum - D_FULL) : AW'(rd_sum);
    rd_dist = (rd_addr == '0) ? '0 : (D_FULL - {1'b0, rd_addr});
    rd_ok   = rd_dist < fill;
  end

  assign drained   = !v1 && !v2 && !mac_stat.busy;
  assign scl_start = (state == S_DRAIN) && drained && !m_axis_tvalid;

  assign mac_ctrl.clear = in_acc && (s_axis_tuser == OP_SAMPLE);
  assign mac_ctrl.en    = v2;

  // Sequencer: state, registers and output item
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tap_count     <= TAP_COUNT_RESET;
      output_gain   <= OUTPUT_GAIN_RESET;
      pos           <= '0;
      fill          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_TAP_COUNT:   tap_count   <= cfg_data[TAP_COUNT_WIDTH-1:0];
          REG_OUTPUT_GAIN: output_gain <= cfg_data[GAIN_WIDTH-1:0];
          default: ;
        endcase
      end

      if (scl_stat.done) begin
        out_sample    <= scl_result;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == OP_SAMPLE) begin
              fill     <= (fill == D_FULL) ? fill : fill + (AW + 1)'(1);
              tap      <= TW'(1);
              tap_last <= TW'(taps_c - TCW'(1));
              state    <= S_RUN;
            end else if (idx_ok) begin
              rem       <= RW'(in_off);
              dsh       <= DSH_INIT;
              load_idx  <= TW'(in_idx);
              load_coef <= in_coef;
              state     <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          rem <= rem_next;
          dsh <= dsh >> 1;
          if (dsh == D_RW) begin
            state <= S_IDLE;
          end
        end
        S_RUN: begin
          // Issue one tap per cycle
          if (tap == tap_last) begin
            state <= S_DRAIN;
          end else begin
            tap <= tap + TW'(1);
          end
        end
        S_DRAIN: begin
          if (scl_start) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (scl_stat.done) begin
            pos   <= (pos == '0) ? POS_LAST : pos - AW'(1);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == S_RUN);
      v2 <= v1;
    end
  end

  // Delay line: write the new sample on accept, read one tap per cycle
  always_ff @(posedge clk) begin
    if (in_acc && (s_axis_tuser == OP_SAMPLE)) begin
      dl_mem[pos] <= in_sample;
    end
    dl_q  <= dl_mem[rd_addr];
    coef2 <= tab_coef;
    ok2   <= rd_ok;
  end

  assign m_axis_tdata = OUT_W'(out_sample);

  stf_tables #(
    .MAX_TAPS    (MAX_TAPS),
    .DELAY_DEPTH (DELAY_DEPTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_tables (
    .clk       (clk),
    .wr_en     (tab_we),
    .wr_addr   (load_idx),
    .wr_offset (AW'(rem_next)),
    .wr_coef   (load_coef),
    .rd_addr   (tap),
    .rd_offset (tab_offset),
    .rd_coef   (tab_coef)
  );

  stf_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (ok2 ? dl_q : '0),
    .coef   (coef2),
    .stat   (mac_stat),
    .acc    (acc)
  );

  stf_scale #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (scl_start),
    .acc    (acc),
    .gain   (output_gain),
    .stat   (scl_stat),
    .result (scl_result)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= D_FULL)
    else $error("fill count beyond delay depth");

  a_scale_free: assert property (@(posedge clk) disable iff (rst)
    scl_start |-> !scl_stat.busy && !m_axis_tvalid)
    else $error("scaler started while busy or output occupied");

  a_out_from_scale: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(scl_stat.done))
    else $error("result shown without a finished scale");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    mac_ctrl.clear |-> !v1 && !v2 && !mac_stat.busy)
    else $error("accumulator cleared with taps in flight");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sparse_tap_fir_filter
// A queue-fed driver offers tap loads and audio samples on s_axis with random
// gaps. A scoreboard model of the delay line, tap tables and gain stage
// predicts each filtered sample when its item is accepted. The monitor
// compares every m_axis result against the oldest prediction while applying
// its own random back-pressure, including two long hold-offs that fill the
// block and stall its input. Registers change only between phases, once
// the block has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import stf_pkg::*;

  localparam int DEPTH       = DELAY_DEPTH_DEF;
  localparam int TAPS        = MAX_TAPS_DEF;
  localparam int FIELD_W     = TAP_INDEX_WIDTH + TAP_OFFSET_WIDTH + COEF_WIDTH_DEF
                               + SAMPLE_WIDTH_DEF;
  localparam int IN_W        = ((FIELD_W + 7) / 8) * 8;
  localparam int FILL_W      = IN_W - FIELD_W;
  localparam int HOLD_CYCLES = 700;
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_PHASES = 16;
  localparam int PRINT_CAP   = 200;
  localparam int LONG_TAPS   = 300;

  // Register indexes past the two real registers; writes there do nothing
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;

  localparam logic signed [23:0] SMP_MAX  = 24'sh7FFFFF;
  localparam logic signed [23:0] SMP_MIN  = -24'sh800000;
  localparam logic signed [17:0] COEF_MAX = 18'sh1FFFF;
  localparam logic signed [17:0] COEF_MIN = -18'sh20000;
  localparam logic [14:0]        OFFS_MAX = 15'h7FFF;

  typedef struct {
    logic                     op;
    logic [9:0]               idx;
    logic [14:0]              offs;
    logic signed [17:0]       coef;
    logic signed [23:0]       smp;
  } fir_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // tdata, low bit up: tap_index, tap_offset, tap_coef, sample_in, zero fill
  logic [IN_W-1:0] s_axis_tdata  = '0;
  // tuser: op
  logic            s_axis_tuser  = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  // tdata, low bit up: sample_out
  logic [23:0]     m_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic                       cfg_wen   = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

  sparse_tap_fir_filter DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model: delay line, write position, tap tables, registers
  // --------------------------------------------------------------------------
  bit signed [23:0]   delay_mem [DEPTH];
  bit [14:0]          wr_pos;
  bit [14:0]          offs_mem  [TAPS];
  bit signed [17:0]   coef_mem  [TAPS];
  bit [9:0]           reg_taps = TAP_COUNT_RESET;
  bit [17:0]          reg_gain = OUTPUT_GAIN_RESET;

  logic [23:0] filtered_q [$];   // predicted outputs, oldest first
  fir_item_t   item_q [$];       // items waiting for the driver
  bit          tap_written [TAPS];

  int n_errors, n_results, n_clipped, n_samples, n_loads, n_phases;
  bit idle_on = 1'b1;
  int hold_req, hold_seen;

  // Clamp the window the way the block does: below two acts as two
  function automatic int eff_taps();
    return (reg_taps < 2) ? 2 : int'(reg_taps);
  endfunction

  function automatic void load_tap(fir_item_t it);
    offs_mem[it.idx] = it.offs;
    coef_mem[it.idx] = it.coef;
  endfunction

  // Store the sample, sum taps 1 .. count-1, scale, round, clip, step back
  function automatic logic [23:0] filter_sample(logic signed [23:0] x);
    longint      acc;
    bit [14:0]   rd;
    bit          neg;
    logic [63:0] mag;
    logic [127:0] q;
    logic [23:0] y;
    delay_mem[wr_pos] = x;
    acc = 0;
    for (int t = 1; t < eff_taps(); t++) begin
      rd  = wr_pos + offs_mem[t];
      acc += longint'(delay_mem[rd]) * longint'(coef_mem[t]);
    end
    neg = acc < 0;
    mag = neg ? 64'(-acc) : 64'(acc);
    // Q1.23 x Q2.16 x Q2.16 leaves 55 fraction bits; drop 32 with rounding
    q = ((128'(mag) * 128'(reg_gain)) + (128'd1 << 31)) >> 32;
    if (neg) begin
      if (q > (128'd1 << 23)) begin
        q = 128'd1 << 23;
        n_clipped++;
      end
      y = 24'(-q);
    end else begin
      if (q > ((128'd1 << 23) - 1)) begin
        q = (128'd1 << 23) - 1;
        n_clipped++;
      end
      y = q[23:0];
    end
    wr_pos = wr_pos - 1'b1;
    return y;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] want, logic [23:0] got);
    if (n_errors < PRINT_CAP)
      $display("%0t: %s: expected %0d, got %0d", $time, what, $signed(want), $signed(got));
    n_errors++;
  endtask

  // Mostly short gaps, a few long ones; none in the no-idle phase
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: pop the next item once the current one is taken, predict on accept
  // --------------------------------------------------------------------------
  fir_item_t cur_item;
  int        gap_left;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_item.op == OP_SAMPLE) filtered_q.push_back(filter_sample(cur_item.smp));
        else load_tap(cur_item);
        gap_left = draw_gap();
      end
      // Hold the item until it is taken; otherwise advance or idle
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (item_q.size() > 0) begin
          cur_item = item_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_item.op;
          s_axis_tdata  <= {{FILL_W{1'b0}}, cur_item.smp, cur_item.coef,
                            cur_item.offs, cur_item.idx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result, drive back-pressure and the long hold-off
  // --------------------------------------------------------------------------
  int hold_left, stall_left;

  always @(posedge clk) begin : monitor
    logic [23:0] want;
    bit          ready_n;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (filtered_q.size() == 0) begin
          report_mismatch("result with no sample pending", '0, m_axis_tdata);
        end else begin
          want = filtered_q.pop_front();
          if (m_axis_tdata !== want) report_mismatch("sample_out", want, m_axis_tdata);
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_n = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_n = 1'b0;
      end else begin
        ready_n = 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left = draw_gap();
      end
      m_axis_tready <= ready_n;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves on either side for too long
  // --------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("[sparse_tap_fir_filter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_load(logic [9:0] idx, logic [14:0] offs, logic signed [17:0] coef);
    fir_item_t it;
    it.op   = OP_LOAD_TAP;
    it.idx  = idx;
    it.offs = offs;
    it.coef = coef;
    it.smp  = 24'($urandom());     // unused field, keep it noisy
    item_q.push_back(it);
    tap_written[idx] = 1'b1;
    n_loads++;
  endtask

  task automatic push_sample(logic signed [23:0] x);
    fir_item_t it;
    it.op   = OP_SAMPLE;
    it.idx  = 10'($urandom());     // unused fields, keep them noisy
    it.offs = 15'($urandom());
    it.coef = 18'($urandom());
    it.smp  = x;
    item_q.push_back(it);
    n_samples++;
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return ($urandom_range(0, 1) != 0) ? 24'sd0 : -24'sd1;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [14:0] rand_offset();
    case ($urandom_range(0, 3))
      0:       return 15'($urandom_range(0, 64));
      1:       return ($urandom_range(0, 1) != 0) ? OFFS_MAX : 15'd0;
      default: return 15'($urandom());
    endcase
  endfunction

  function automatic logic signed [17:0] rand_coef();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
    return 18'($urandom());
  endfunction

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    if (idx == REG_TAP_COUNT) reg_taps = data[9:0];
    else if (idx == REG_OUTPUT_GAIN) reg_gain = data;
    n_phases++;
    @(negedge clk);
  endtask

  // Wait until every item is taken and every result is in, then let any
  // trailing tap load finish before the registers may change
  task automatic wait_drained();
    while (!(item_q.size() == 0 && !s_axis_tvalid && filtered_q.size() == 0))
      @(negedge clk);
    repeat (eff_taps() + 32) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int               taps_sel;
    int               n_items;
    logic [17:0]      gain_sel;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: window of two, so only tap 1 is read. Offset zero
    // makes the tap see the sample just stored; both table ends get a write.
    push_load(10'd1, 15'd0, COEF_MAX);
    push_load(10'd0, OFFS_MAX, COEF_MIN);
    push_load(10'd1023, OFFS_MAX, COEF_MIN);
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    push_sample(24'sd0);
    push_sample(24'sd1);
    wait_drained();

    // Window below two acts as two; full gain drives both rails into clipping
    write_reg(REG_TAP_COUNT, 18'd0);
    write_reg(REG_OUTPUT_GAIN, 18'h3FFFF);
    write_reg(REG_SPARE_2, 18'h2AAAA);
    write_reg(REG_SPARE_3, 18'h15555);
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    wait_drained();

    // Window of one; bits above the register width drop. Zero gain.
    write_reg(REG_TAP_COUNT, 18'h3FC01);
    write_reg(REG_OUTPUT_GAIN, 18'd0);
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    wait_drained();

    // Four taps, unity gain; the largest offset wraps the read address
    write_reg(REG_TAP_COUNT, 18'd4);
    write_reg(REG_OUTPUT_GAIN, 18'd65536);
    push_load(10'd2, OFFS_MAX, COEF_MIN);
    push_load(10'd3, 15'd1, 18'sd1);
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    push_sample(-24'sd1);
    push_sample(rand_sample());
    push_sample(rand_sample());
    wait_drained();

    // Random phases: mostly short windows, two long ones, one mid-size
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 7 || p == RAND_PHASES - 1) taps_sel = LONG_TAPS;
      else if (p == 10) taps_sel = $urandom_range(100, 250);
      else if (p == 0) taps_sel = $urandom_range(0, 1);
      else taps_sel = $urandom_range(2, 40);

      if (p == 1) gain_sel = 18'd0;
      else if (p == 2) gain_sel = 18'h3FFFF;
      else if ($urandom_range(0, 1) != 0) gain_sel = 18'($urandom_range(0, 4095));
      else gain_sel = 18'($urandom());

      if ($urandom_range(0, 1) != 0) begin
        write_reg(REG_TAP_COUNT, 18'(taps_sel));
        write_reg(REG_OUTPUT_GAIN, gain_sel);
      end else begin
        write_reg(REG_OUTPUT_GAIN, gain_sel);
        write_reg(REG_TAP_COUNT, 18'(taps_sel));
      end
      if (p % 5 == 3) write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_2 : REG_SPARE_3,
                                18'($urandom()));

      idle_on = (p != 6);
      // Hold off the receiver while the sender keeps offering
      if (p == 4 || p == 11) hold_req++;

      // Load every tap the window reads that has never been written
      for (int t = 1; t < eff_taps(); t++)
        if (!tap_written[t]) push_load(10'(t), rand_offset(), rand_coef());

      n_items = (eff_taps() >= 100) ? 8 : 20;
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 99) < 70) push_sample(rand_sample());
        else push_load(10'($urandom_range(0, TAPS - 1)), rand_offset(), rand_coef());
      end
      wait_drained();
    end

    if (filtered_q.size() != 0) report_mismatch("prediction never answered", filtered_q[0], '0);

    $display("run covered %0d samples and %0d tap loads across %0d register writes",
             n_samples, n_loads, n_phases);
    $display("%0d results checked, %0d of them clipped, %0d mismatches",
             n_results, n_clipped, n_errors);
    if (n_errors == 0) begin
      $display("[sparse_tap_fir_filter] OK");
    end else begin
      $display("[sparse_tap_fir_filter] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/stf_pkg.sv
hdl/stf_tables.sv
hdl/stf_mac.sv
hdl/stf_scale.sv
hdl/sparse_tap_fir_filter.sv
sim/tb_top.sv
